[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RWS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define RWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rws_pkg.sv]
package rws_pkg;

    // Default size limits of the height map.
    localparam int MaxWidthDef  = 512;
    localparam int MaxHeightDef = 512;

    // Smallest row width and row count that the block works with.
    localparam int MinDim = 3;

    // Fixed field widths.
    localparam int HeightW = 16;
    localparam int PosW    = 18;
    localparam int CfgW    = 10;

    // Configuration port.
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;

    // Register indexes, taken from paddr[2].
    localparam logic RegFrameWidth  = 1'b0;
    localparam logic RegFrameHeight = 1'b1;

    // Reset values of the registers.
    localparam logic [CfgW-1:0] FrameWidthRst  = 10'd512;
    localparam logic [CfgW-1:0] FrameHeightRst = 10'd512;

    // Shift amounts of the wave equation.
    localparam int HalfShift = 1;
    localparam int DampShift = 5;

    // Raw register contents as seen by the datapath.
    typedef struct packed {
        logic [CfgW-1:0] frame_width;
        logic [CfgW-1:0] frame_height;
    } cfg_regs_t;

    // Neighbor heights and tags of one result position, handed to the arithmetic.
    typedef struct packed {
        logic signed [HeightW-1:0] h_right;
        logic signed [HeightW-1:0] h_left;
        logic signed [HeightW-1:0] h_above;
        logic signed [HeightW-1:0] h_below;
        logic signed [HeightW-1:0] older;
        logic [PosW-1:0]           position;
        logic                      last;
    } tap_set_t;

endpackage

[rtl/rws_in_if.sv]
interface rws_in_if;

    logic                               valid;
    logic                               ready;
    logic                               frame_start;
    logic signed [rws_pkg::HeightW-1:0] cur_height;
    logic signed [rws_pkg::HeightW-1:0] older_height;

    modport source (
        output valid,
        output frame_start,
        output cur_height,
        output older_height,
        input  ready
    );

    modport sink (
        input  valid,
        input  frame_start,
        input  cur_height,
        input  older_height,
        output ready
    );

endinterface

[rtl/rws_out_if.sv]
interface rws_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [rws_pkg::HeightW-1:0] new_height;
    logic [rws_pkg::PosW-1:0]           position;
    logic                               last_of_frame;

    modport source (
        output valid,
        output new_height,
        output position,
        output last_of_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  new_height,
        input  position,
        input  last_of_frame,
        output ready
    );

endinterface

[rtl/rws_cfg.sv]
module rws_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rws_pkg::CfgAddrW-1:0]  paddr,
    input  logic [rws_pkg::CfgDataW-1:0]  pwdata,
    output logic [rws_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    output rws_pkg::cfg_regs_t            cfg
);

    rws_pkg::cfg_regs_t cfg_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= rws_pkg::FrameWidthRst;
            cfg_reg.frame_height <= rws_pkg::FrameHeightRst;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                rws_pkg::RegFrameWidth:
                    cfg_reg.frame_width <= pwdata[rws_pkg::CfgW-1:0];
                rws_pkg::RegFrameHeight:
                    cfg_reg.frame_height <= pwdata[rws_pkg::CfgW-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read data returns the addressed register, zero extended.
    always_comb
    begin
        case (paddr[2])
            rws_pkg::RegFrameWidth:
                prdata = rws_pkg::CfgDataW'(cfg_reg.frame_width);
            rws_pkg::RegFrameHeight:
                prdata = rws_pkg::CfgDataW'(cfg_reg.frame_height);
            default:
                prdata = '0;
        endcase
    end

endmodule

[rtl/rws_tap_cell.sv]
module rws_tap_cell #(
    parameter int AddrW = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic signed [rws_pkg::HeightW-1:0] din,
    input  logic [AddrW-1:0]                   offset,
    output logic signed [rws_pkg::HeightW-1:0] tap
);

    localparam int Depth = 1 << AddrW;

    logic signed [rws_pkg::HeightW-1:0] line_mem [Depth];
    logic [AddrW-1:0]                   wr_ptr_reg;
    logic [AddrW-1:0]                   rd_addr;
    logic signed [rws_pkg::HeightW-1:0] tap_reg;

    // The read slot lies offset items behind the slot being written.
    assign rd_addr = wr_ptr_reg - offset;
    assign tap     = tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
        end
        else if (advance)
        begin
            wr_ptr_reg <= wr_ptr_reg + 1'b1;
        end
    end

    // Ring buffer: the read sees the old contents when both hit the same slot.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_mem[wr_ptr_reg] <= din;
            tap_reg              <= line_mem[rd_addr];
        end
    end

endmodule

[rtl/rws_wave_calc.sv]
module rws_wave_calc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  rws_pkg::tap_set_t taps,
    output logic              take,
    rws_out_if.source         result
);

    localparam int SumW  = rws_pkg::HeightW + 2;
    localparam int HalfW = SumW - rws_pkg::HalfShift;
    localparam int VW    = SumW;
    localparam int DW    = VW + 1;
    localparam logic signed [DW-1:0] SatHi = DW'(32767);
    localparam logic signed [DW-1:0] SatLo = -DW'(32768);

    logic                               s2_vld_reg;
    logic signed [VW-1:0]               v_reg;
    logic [rws_pkg::PosW-1:0]           s2_pos_reg;
    logic                               s2_last_reg;
    logic                               out_vld_reg;
    logic signed [rws_pkg::HeightW-1:0] out_height_reg;
    logic [rws_pkg::PosW-1:0]           out_pos_reg;
    logic                               out_last_reg;

    logic                               out_load;
    logic                               s2_load;
    logic signed [SumW-1:0]             sum;
    logic signed [HalfW-1:0]            half;
    logic signed [VW-1:0]               v_next;
    logic signed [DW-1:0]               damp;
    logic signed [rws_pkg::HeightW-1:0] height_next;

    // Each stage moves on when it is empty or the stage after it moves.
    assign out_load = !out_vld_reg || result.ready;
    assign s2_load  = !s2_vld_reg || out_load;
    assign take     = s2_load;

    // Neighbor sum, halved, less the older height.
    always_comb
    begin
        sum    = SumW'(taps.h_right) + SumW'(taps.h_left)
               + SumW'(taps.h_above) + SumW'(taps.h_below);
        half   = HalfW'(sum >>> rws_pkg::HalfShift);
        v_next = VW'(half) - VW'(taps.older);
    end

    // Damping and saturation to the height range.
    always_comb
    begin
        damp = DW'(v_reg) - DW'(v_reg >>> rws_pkg::DampShift);
        if (damp > SatHi)
        begin
            height_next = rws_pkg::HeightW'(SatHi);
        end
        else if (damp < SatLo)
        begin
            height_next = rws_pkg::HeightW'(SatLo);
        end
        else
        begin
            height_next = rws_pkg::HeightW'(damp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s2_load)
            begin
                s2_vld_reg <= in_vld;
            end
            if (out_load)
            begin
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            v_reg       <= v_next;
            s2_pos_reg  <= taps.position;
            s2_last_reg <= taps.last;
        end
        if (out_load)
        begin
            out_height_reg <= height_next;
            out_pos_reg    <= s2_pos_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.new_height    = out_height_reg;
    assign result.position      = out_pos_reg;
    assign result.last_of_frame = out_last_reg;

endmodule

[rtl/ripple_wave_step.sv]
// Ripple height-map wave step.
// Input items arrive on the sample channel in raster order, one height per item;
// frame_start marks position zero and restarts the position count. Each item
// also carries the older height of the position one row back. Result items
// leave on the result channel with valid/ready: the damped, saturated new height
// of the position one row behind the input, its linear index, and a flag on the
// last result of the frame. Rows zero and height-1 give no result.
// The frame size is set through the APB registers frame_width (0x0) and
// frame_height (0x4), written while no item is in flight.
// Throughput is one item per clock while the receiver keeps up. After its item
// is accepted, a result passes the registered stages tap read, neighbor sum and
// damping, into the output register. Three ring buffers of tap cells hold the
// past heights, each with one write and one read per accepted item; their
// contents are undefined until two rows of a frame have streamed in. Reset clears
// the position count and the pipeline valid bits, with no clearing pass. When the
// receiver stalls, the result stays in the output register and the stages before
// it fill; sample.ready falls only when all three stages hold items.
module ripple_wave_step #(
    parameter int MaxWidth  = rws_pkg::MaxWidthDef,
    parameter int MaxHeight = rws_pkg::MaxHeightDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rws_in_if.sink                       sample,
    rws_out_if.source                    result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rws_pkg::CfgAddrW-1:0] paddr,
    input  logic [rws_pkg::CfgDataW-1:0] pwdata,
    output logic [rws_pkg::CfgDataW-1:0] prdata,
    output logic                         pready
);

    localparam int WW     = $clog2(MaxWidth + 1);
    localparam int HW     = $clog2(MaxHeight + 1);
    localparam int PW     = $clog2(MaxWidth * MaxHeight + 1);
    localparam int NearAw = $clog2(MaxWidth + 1);
    localparam int FarAw  = $clog2(2 * MaxWidth);

    rws_pkg::cfg_regs_t cfg;
    rws_pkg::tap_set_t  taps;

    logic [WW-1:0]      w;
    logic [HW-1:0]      h;
    logic [PW-1:0]      total;
    logic [PW-1:0]      pos;
    logic [PW-1:0]      cnt_reg;
    logic [PW-1:0]      cnt_next;
    logic [PW-1:0]      res_index;
    logic               emit;
    logic               accept;
    logic               s1_load;
    logic               take;
    logic               s1_vld_reg;
    logic signed [rws_pkg::HeightW-1:0] cur_reg;
    logic signed [rws_pkg::HeightW-1:0] older_reg;
    logic [rws_pkg::PosW-1:0]           pos_reg;
    logic                               last_reg;
    logic signed [rws_pkg::HeightW-1:0] tap_right;
    logic signed [rws_pkg::HeightW-1:0] tap_left;
    logic signed [rws_pkg::HeightW-1:0] tap_above;
    logic [NearAw-1:0]  off_right;
    logic [NearAw-1:0]  off_left;
    logic [FarAw-1:0]   off_above;

    rws_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame size held to the supported range.
    always_comb
    begin
        if (32'(cfg.frame_width) < rws_pkg::MinDim)
        begin
            w = WW'(rws_pkg::MinDim);
        end
        else if (32'(cfg.frame_width) > MaxWidth)
        begin
            w = WW'(MaxWidth);
        end
        else
        begin
            w = WW'(cfg.frame_width);
        end

        if (32'(cfg.frame_height) < rws_pkg::MinDim)
        begin
            h = HW'(rws_pkg::MinDim);
        end
        else if (32'(cfg.frame_height) > MaxHeight)
        begin
            h = HW'(MaxHeight);
        end
        else
        begin
            h = HW'(cfg.frame_height);
        end
    end

    // Position of the incoming item and whether it yields a result.
    always_comb
    begin
        total     = PW'(w) * PW'(h);
        pos       = sample.frame_start ? '0 : cnt_reg;
        emit      = (pos >= (PW'(w) << 1)) && (pos < total);
        res_index = pos - PW'(w);
        cnt_next  = (pos < total) ? pos + 1'b1 : total;
    end

    // Tap distances back from the newest height.
    assign off_right = NearAw'(32'(w) - 1);
    assign off_left  = NearAw'(32'(w) + 1);
    assign off_above = FarAw'(32'(w) << 1);

    assign s1_load      = !s1_vld_reg || take;
    assign sample.ready = s1_load;
    assign accept       = sample.valid && s1_load;

    // Row of tap cells, all advancing on each accepted item.
    rws_tap_cell #(.AddrW(NearAw)) u_cell_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (sample.cur_height),
        .offset  (off_right),
        .tap     (tap_right)
    );

    rws_tap_cell #(.AddrW(NearAw)) u_cell_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (sample.cur_height),
        .offset  (off_left),
        .tap     (tap_left)
    );

    rws_tap_cell #(.AddrW(FarAw)) u_cell_above (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (sample.cur_height),
        .offset  (off_above),
        .tap     (tap_above)
    );

    // Position count and first stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
            if (s1_load)
            begin
                s1_vld_reg <= accept && emit;
            end
        end
    end

    // First stage payload, alongside the tap reads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg   <= sample.cur_height;
            older_reg <= sample.older_height;
            pos_reg   <= rws_pkg::PosW'(res_index);
            last_reg  <= (pos == total - 1'b1);
        end
    end

    always_comb
    begin
        taps.h_right  = tap_right;
        taps.h_left   = tap_left;
        taps.h_above  = tap_above;
        taps.h_below  = cur_reg;
        taps.older    = older_reg;
        taps.position = pos_reg;
        taps.last     = last_reg;
    end

    rws_wave_calc u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (s1_vld_reg),
        .taps   (taps),
        .take   (take),
        .result (result)
    );

endmodule

[rtl/rws_checker.sv]
`include "assert_macros.svh"

module rws_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               r_valid,
    input logic                               r_ready,
    input logic signed [rws_pkg::HeightW-1:0] r_new_height,
    input logic [rws_pkg::PosW-1:0]           r_position,
    input logic                               r_last
);

    // A stalled result keeps its valid and its payload.
    `RWS_ASSERT_CLK(a_result_hold, clk, rst_n, r_valid && !r_ready |=> r_valid && $stable(r_new_height) && $stable(r_position) && $stable(r_last), "result changed while stalled")

    // Reset empties the output register.
    `RWS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !r_valid, "result valid during reset")

    // A new result must follow an accepted item by the tap read, neighbor sum and damping registers.
    `RWS_ASSERT_CLK(a_result_latency, clk, rst_n, $rose(r_valid) |-> $past(s_valid && s_ready, 3), "result without an item accepted three cycles earlier")

endmodule

bind ripple_wave_step rws_checker u_rws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_valid      (sample.valid),
    .s_ready      (sample.ready),
    .r_valid      (result.valid),
    .r_ready      (result.ready),
    .r_new_height (result.new_height),
    .r_position   (result.position),
    .r_last       (result.last_of_frame)
);

[bench/ripple_wave_step_test.sv]
`timescale 1ns / 100ps

localparam int StoreDepth = 2 * rws_pkg::MaxWidthDef + 1;

typedef struct packed {
    logic signed [rws_pkg::HeightW-1:0] new_height;
    logic [rws_pkg::PosW-1:0]           position;
    logic                               last_of_frame;
} wave_result_t;

// Tracks the wave step for every accepted item and keeps the results still owed.
class ripple_scoreboard;
    logic [rws_pkg::CfgW-1:0]           width_reg;
    logic [rws_pkg::CfgW-1:0]           height_reg;
    logic signed [rws_pkg::HeightW-1:0] heights [StoreDepth];
    int unsigned                        head;
    int unsigned                        in_pos;
    wave_result_t                       owed [$];
    int unsigned                        mismatches;
    int unsigned                        checked;

    function new();
        width_reg  = rws_pkg::FrameWidthRst;
        height_reg = rws_pkg::FrameHeightRst;
        head       = 0;
        in_pos     = 0;
        mismatches = 0;
        checked    = 0;
        foreach (heights[j])
        begin
            heights[j] = '0;
        end
    endfunction

    function void write_reg(logic idx, logic [rws_pkg::CfgW-1:0] value);
        if (idx == rws_pkg::RegFrameWidth)
        begin
            width_reg = value;
        end
        else
        begin
            height_reg = value;
        end
    endfunction

    function int unsigned clamp_dim(logic [rws_pkg::CfgW-1:0] raw, int unsigned hi);
        if (raw < rws_pkg::MinDim)
        begin
            return rws_pkg::MinDim;
        end
        if (raw > hi)
        begin
            return hi;
        end
        return int'(raw);
    endfunction

    function int frame_total();
        return clamp_dim(width_reg, rws_pkg::MaxWidthDef) *
               clamp_dim(height_reg, rws_pkg::MaxHeightDef);
    endfunction

    // Height of the position that lies the given number of items back.
    function int height_back(int unsigned back);
        return int'(heights[(head + StoreDepth - back) % StoreDepth]);
    endfunction

    function bit drained();
        return owed.size() == 0;
    endfunction

    // Shifts one accepted item into the history and works out its result, if any.
    function void note_sample(logic fs, logic signed [rws_pkg::HeightW-1:0] cur,
                              logic signed [rws_pkg::HeightW-1:0] older);
        int unsigned  w;
        int unsigned  total;
        int unsigned  pos;
        int           sum;
        int           wave;
        int           damped;
        wave_result_t res;
        w     = clamp_dim(width_reg, rws_pkg::MaxWidthDef);
        total = frame_total();
        pos   = fs ? 0 : in_pos;
        head  = (head + 1) % StoreDepth;
        heights[head] = cur;
        if (pos >= 2 * w && pos < total)
        begin
            sum = height_back(0) + height_back(w - 1) + height_back(w + 1) +
                  height_back(2 * w);
            wave   = (sum >>> rws_pkg::HalfShift) - int'(older);
            damped = wave - (wave >>> rws_pkg::DampShift);
            if (damped > 32767)
            begin
                damped = 32767;
            end
            else if (damped < -32768)
            begin
                damped = -32768;
            end
            res.new_height    = damped[rws_pkg::HeightW-1:0];
            res.position      = rws_pkg::PosW'(pos - w);
            res.last_of_frame = (pos == total - 1);
            owed.push_back(res);
        end
        in_pos = (pos < total) ? pos + 1 : total;
    endfunction

    // Compares one result item with the oldest one owed.
    function void check_result(logic signed [rws_pkg::HeightW-1:0] new_height,
                               logic [rws_pkg::PosW-1:0] position, logic last_of_frame);
        wave_result_t want;
        checked++;
        if (owed.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result item height %0d position %0d last %0b",
                     $time, new_height, position, last_of_frame);
            return;
        end
        want = owed.pop_front();
        if (new_height !== want.new_height)
        begin
            mismatches++;
            $display("%0t: new_height expected %0d actual %0d", $time,
                     want.new_height, new_height);
        end
        if (position !== want.position)
        begin
            mismatches++;
            $display("%0t: position expected %0d actual %0d", $time,
                     want.position, position);
        end
        if (last_of_frame !== want.last_of_frame)
        begin
            mismatches++;
            $display("%0t: last_of_frame expected %0b actual %0b at position %0d", $time,
                     want.last_of_frame, last_of_frame, want.position);
        end
    endfunction
endclass

module ripple_wave_step_test;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [rws_pkg::CfgAddrW-1:0] paddr;
    logic [rws_pkg::CfgDataW-1:0] pwdata;
    logic [rws_pkg::CfgDataW-1:0] prdata;
    logic                         pready;

    rws_in_if  sample_ch ();
    rws_out_if result_ch ();

    ripple_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned frames_sent;
    int unsigned settings_used;
    int unsigned drain_pauses;
    int unsigned phase_items;
    bit          forced_pause_done;

    ripple_wave_step u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // Receiver: random back-pressure and checking of every accepted result item.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.check_result(result_ch.new_height, result_ch.position,
                            result_ch.last_of_frame);
        end
    end

    // Run limit in case the block hangs.
    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic idx, input logic [rws_pkg::CfgW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= rws_pkg::CfgDataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_frame(input logic [rws_pkg::CfgW-1:0] w_raw,
                             input logic [rws_pkg::CfgW-1:0] h_raw);
        apb_write(rws_pkg::RegFrameWidth, w_raw);
        apb_write(rws_pkg::RegFrameHeight, h_raw);
        settings_used++;
    endtask

    // Stops sending until every owed result item has come back.
    task automatic hold_until_drained();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (!sb.drained());
    endtask

    // Drains and lets the pipeline settle so the registers may change.
    task automatic settle();
        hold_until_drained();
        repeat (8) @(posedge clk);
    endtask

    // Offers one item, with random idle cycles first, and waits for acceptance.
    task automatic send_item(input logic fs, input logic signed [rws_pkg::HeightW-1:0] cur,
                             input logic signed [rws_pkg::HeightW-1:0] older);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.frame_start  <= fs;
        sample_ch.cur_height   <= cur;
        sample_ch.older_height <= older;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(fs, cur, older);
        items_sent++;
    endtask

    function automatic logic signed [rws_pkg::HeightW-1:0] pick_height(int style);
        int t;
        case (style)
            0: t = $urandom;
            1: t = int'($urandom_range(0, 1023)) - 512;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: t = 32767;
                    1: t = -32768;
                    2: t = 0;
                    default: t = -1;
                endcase
            end
        endcase
        return t[rws_pkg::HeightW-1:0];
    endfunction

    // One frame of len items from position zero, then tail items past its end.
    task automatic stream_frame(input int unsigned len, input int unsigned tail,
                                input int style);
        for (int unsigned k = 0; k < len; k++)
        begin
            if ((!forced_pause_done && k == len / 2 && k > 0) ||
                $urandom_range(0, 399) == 0)
            begin
                forced_pause_done = 1'b1;
                drain_pauses++;
                hold_until_drained();
            end
            send_item(k == 0, pick_height(style), pick_height(style));
        end
        for (int unsigned j = 0; j < tail; j++)
        begin
            send_item(1'b0, pick_height(style), pick_height(style));
        end
        frames_sent++;
        phase_items += len + tail;
    endtask

    // A phase: one setting, then frames until the item budget is used up.
    task automatic random_phase(input bit smallest);
        int unsigned total;
        int unsigned kind;
        if (smallest)
        begin
            set_frame(10'd3, 10'd3);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: set_frame(10'($urandom_range(0, 2)), 10'($urandom_range(3, 8)));
                1: set_frame(10'($urandom_range(3, 6)), 10'($urandom_range(0, 2)));
                default: set_frame(10'($urandom_range(3, 16)), 10'($urandom_range(3, 8)));
            endcase
        end
        total = sb.frame_total();
        phase_items = 0;
        while (phase_items < 40)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                stream_frame($urandom_range(1, total - 1), 0, $urandom_range(0, 2));
            end
            else if (kind == 1)
            begin
                stream_frame(total, $urandom_range(1, 4), $urandom_range(0, 2));
            end
            else
            begin
                stream_frame(total, 0, $urandom_range(0, 2));
            end
        end
        settle();
    endtask

    initial
    begin
        int unsigned wait_cycles;
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.frame_start  <= 1'b0;
        sample_ch.cur_height   <= '0;
        sample_ch.older_height <= '0;
        send_idle_pct          = 0;
        recv_idle_pct          = 0;
        items_sent             = 0;
        frames_sent            = 0;
        settings_used          = 0;
        drain_pauses           = 0;
        forced_pause_done      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: registers below range clamp to a 3 by 3 frame.
        set_frame(10'd0, 10'd2);
        // Largest heights with the smallest older height saturate high.
        for (int k = 0; k < 9; k++)
        begin
            send_item(k == 0, 16'sd32767, -16'sd32768);
        end
        // Items past the end of the frame leave the counter held.
        send_item(1'b0, 16'sd5, 16'sd3);
        send_item(1'b0, -16'sd7, 16'sd1);
        // A frame cut short, then a restart that saturates low.
        for (int k = 0; k < 4; k++)
        begin
            send_item(k == 0, -16'sd32768, 16'sd32767);
        end
        for (int k = 0; k < 9; k++)
        begin
            send_item(k == 0, -16'sd32768, 16'sd32767);
        end
        settle();

        // Random phases under three idling patterns.
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 71 : 0;
            recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 32 : 0;
            for (int p = 0; p < 4; p++)
            begin
                random_phase(mode == 0 && p == 0);
            end
        end

        // A wide frame in full, then a height above range with a frame cut short.
        set_frame(10'd150, 10'd1);
        stream_frame(sb.frame_total(), 0, 0);
        settle();
        set_frame(10'd3, 10'd1023);
        stream_frame(40, 0, 1);

        // Wait for every owed result, then let the pipeline settle before the summary.
        sample_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (!sb.drained() && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (!sb.drained())
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            repeat (8) @(posedge clk);
            $display("Streamed %0d items in %0d frames over %0d frame sizes, %0d drain pauses.",
                     items_sent, frames_sent, settings_used, drain_pauses);
            $display("Checked %0d result items, %0d field mismatches.",
                     sb.checked, sb.mismatches);
            if (sb.mismatches == 0 && sb.drained())
            begin
                $display("RESULT: OK");
            end
            else
            begin
                $display("RESULT: ERROR");
            end
            $finish;
        end
    end

endmodule
